/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/i2cbe_pkg.sv */
// Types, codes and helper functions of the I2C master bit engine.
package i2cbe_pkg;

    // Raw command codes on the kind field.
    localparam logic [2:0] KIND_TICK  = 3'd0;
    localparam logic [2:0] KIND_START = 3'd1;
    localparam logic [2:0] KIND_STOP  = 3'd2;
    localparam logic [2:0] KIND_WRITE = 3'd3;
    localparam logic [2:0] KIND_READ  = 3'd4;
    localparam logic [2:0] KIND_WAIT  = 3'd5;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ACK_TIMEOUT = 2'd0;
    localparam logic [1:0] CFG_COND_TICKS  = 2'd1;
    localparam logic [1:0] CFG_HALF_BIT    = 2'd2;

    // Configuration reset values.
    localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;
    localparam logic [3:0] COND_TICKS_RST  = 4'd4;
    localparam logic [3:0] HALF_BIT_RST    = 4'd2;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef enum logic [2:0] {
        OP_TICK,
        OP_START,
        OP_STOP,
        OP_WRITE,
        OP_READ,
        OP_WAIT,
        OP_NONE
    } op_t;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_ST_A,
        PH_ST_B,
        PH_SP_A,
        PH_SP_B,
        PH_WR_LOW,
        PH_WR_HIGH,
        PH_WR_TAIL,
        PH_RD_LOW,
        PH_RD_HIGH,
        PH_AK_LOW,
        PH_AK_HIGH,
        PH_WA_A,
        PH_WA_B,
        PH_WA_POLL
    } phase_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data_byte;
        logic       send_ack;
        logic       sda_in;
    } item_t;

    // A zero phase length behaves as one tick.
    function automatic logic [7:0] at_least_one(input logic [3:0] v);
        logic [7:0] r;
        r = {4'd0, v};
        if (v == 4'd0)
        begin
            r = 8'd1;
        end
        return r;
    endfunction

endpackage

/* hw/rtl/i2cbe_front.sv */
// Front end: takes input beats and classifies the command code.
module i2cbe_front
    import i2cbe_pkg::*;
(
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  kind,
    input  logic [7:0]  data_byte,
    input  logic        send_ack,
    input  logic        sda_in,
    input  logic        q_full,
    output logic        q_push,
    output item_t       q_item
);

    op_t op;

    always_comb
    begin
        case (kind)
            KIND_TICK:  op = OP_TICK;
            KIND_START: op = OP_START;
            KIND_STOP:  op = OP_STOP;
            KIND_WRITE: op = OP_WRITE;
            KIND_READ:  op = OP_READ;
            KIND_WAIT:  op = OP_WAIT;
            default:    op = OP_NONE;
        endcase
    end

    assign in_stall         = q_full;
    assign q_push           = in_valid && !q_full;
    assign q_item.op        = op;
    assign q_item.data_byte = data_byte;
    assign q_item.send_ack  = send_ack;
    assign q_item.sda_in    = sda_in;

endmodule

/* hw/rtl/i2cbe_queue.sv */
// Small FIFO of classified items between the front end and the engine.
module i2cbe_queue
    import i2cbe_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  valid,
    output item_t head
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    item_t          slot_reg [DEPTH];
    logic [IW-1:0]  wr_ptr_reg;
    logic [IW-1:0]  wr_ptr_next;
    logic [IW-1:0]  rd_ptr_reg;
    logic [IW-1:0]  rd_ptr_next;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic           do_pop;

    assign full   = (count_reg == FULL_COUNT);
    assign valid  = (count_reg != '0);
    assign head   = slot_reg[rd_ptr_reg];
    assign do_pop = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* hw/rtl/i2cbe_back.sv */
// Bit engine: SCL/SDA sequencer, one item per cycle unless stalled, result held.
module i2cbe_back
    import i2cbe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata,
    input  logic        q_valid,
    input  item_t       q_head,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        scl_level,
    output logic        sda_pull_low,
    output logic        busy_res,
    output logic        done_res,
    output logic [7:0]  read_data,
    output logic        ack_failed
);

    logic [7:0] ack_timeout_reg;
    logic [3:0] cond_ticks_reg;
    logic [3:0] half_bit_reg;

    phase_t     phase_reg,  phase_next;
    logic [7:0] tick_reg,   tick_next;
    logic [3:0] bit_reg,    bit_next;
    logic [7:0] shift_reg,  shift_next;
    logic [7:0] rx_reg,     rx_next;
    logic       scl_reg,    scl_next;
    logic       sda_reg,    sda_next;
    logic       ack_mode_reg, ack_mode_next;
    logic       fail_reg,   fail_next;
    logic       done_reg,   done_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;
    logic       go;

    assign slot_free = !out_valid_reg || !out_stall;
    assign go        = slot_free && q_valid;
    assign q_pop     = go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ack_timeout_reg <= ACK_TIMEOUT_RST;
            cond_ticks_reg  <= COND_TICKS_RST;
            half_bit_reg    <= HALF_BIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ACK_TIMEOUT: ack_timeout_reg <= cfg_wdata;
                CFG_COND_TICKS:  cond_ticks_reg  <= cfg_wdata[3:0];
                CFG_HALF_BIT:    half_bit_reg    <= cfg_wdata[3:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        phase_next    = phase_reg;
        tick_next     = tick_reg;
        bit_next      = bit_reg;
        shift_next    = shift_reg;
        rx_next       = rx_reg;
        scl_next      = scl_reg;
        sda_next      = sda_reg;
        ack_mode_next = ack_mode_reg;
        fail_next     = fail_reg;
        done_next     = done_reg;
        out_valid_next = out_valid_reg && out_stall;

        if (go)
        begin
            out_valid_next = 1'b1;
            done_next      = 1'b0;
            if (q_head.op == OP_TICK)
            begin
                if (phase_reg == PH_WA_POLL)
                begin
                    if (!q_head.sda_in)
                    begin
                        scl_next   = 1'b0;
                        phase_next = PH_IDLE;
                        done_next  = 1'b1;
                    end
                    else if (tick_reg >= ack_timeout_reg)
                    begin
                        // Timeout: flag it and release the bus with a stop.
                        fail_next  = 1'b1;
                        scl_next   = 1'b0;
                        sda_next   = 1'b1;
                        phase_next = PH_SP_A;
                        tick_next  = at_least_one(cond_ticks_reg);
                    end
                    else
                    begin
                        tick_next = tick_reg + 8'd1;
                    end
                end
                else if (phase_reg != PH_IDLE)
                begin
                    if (tick_reg > 8'd1)
                    begin
                        tick_next = tick_reg - 8'd1;
                    end
                    else
                    begin
                        case (phase_reg)
                            PH_ST_A:
                            begin
                                sda_next   = 1'b1;
                                phase_next = PH_ST_B;
                                tick_next  = at_least_one(cond_ticks_reg);
                            end
                            PH_ST_B:
                            begin
                                scl_next   = 1'b0;
                                phase_next = PH_IDLE;
                                done_next  = 1'b1;
                            end
                            PH_SP_A:
                            begin
                                scl_next   = 1'b1;
                                sda_next   = 1'b0;
                                phase_next = PH_SP_B;
                                tick_next  = at_least_one(cond_ticks_reg);
                            end
                            PH_SP_B:
                            begin
                                phase_next = PH_IDLE;
                                done_next  = 1'b1;
                            end
                            PH_WR_LOW:
                            begin
                                scl_next   = 1'b1;
                                phase_next = PH_WR_HIGH;
                                tick_next  = at_least_one(half_bit_reg);
                            end
                            PH_WR_HIGH:
                            begin
                                scl_next   = 1'b0;
                                phase_next = PH_WR_TAIL;
                                tick_next  = at_least_one(half_bit_reg);
                            end
                            PH_WR_TAIL:
                            begin
                                bit_next = bit_reg + 4'd1;
                                if (bit_next >= BITS_PER_BYTE)
                                begin
                                    phase_next = PH_IDLE;
                                    done_next  = 1'b1;
                                end
                                else
                                begin
                                    shift_next = {shift_reg[6:0], 1'b0};
                                    sda_next   = !shift_reg[6];
                                    phase_next = PH_WR_LOW;
                                    tick_next  = at_least_one(half_bit_reg);
                                end
                            end
                            PH_RD_LOW:
                            begin
                                scl_next   = 1'b1;
                                rx_next    = {rx_reg[6:0], q_head.sda_in};
                                phase_next = PH_RD_HIGH;
                                tick_next  = 8'd1;
                            end
                            PH_RD_HIGH:
                            begin
                                bit_next  = bit_reg + 4'd1;
                                scl_next  = 1'b0;
                                tick_next = at_least_one(half_bit_reg);
                                if (bit_next >= BITS_PER_BYTE)
                                begin
                                    sda_next   = ack_mode_reg;
                                    phase_next = PH_AK_LOW;
                                end
                                else
                                begin
                                    phase_next = PH_RD_LOW;
                                end
                            end
                            PH_AK_LOW:
                            begin
                                scl_next   = 1'b1;
                                phase_next = PH_AK_HIGH;
                                tick_next  = at_least_one(half_bit_reg);
                            end
                            PH_AK_HIGH:
                            begin
                                scl_next   = 1'b0;
                                phase_next = PH_IDLE;
                                done_next  = 1'b1;
                            end
                            PH_WA_A:
                            begin
                                scl_next   = 1'b1;
                                phase_next = PH_WA_B;
                                tick_next  = 8'd1;
                            end
                            PH_WA_B:
                            begin
                                phase_next = PH_WA_POLL;
                                tick_next  = 8'd0;
                            end
                            default:
                            begin
                                phase_next = PH_IDLE;
                            end
                        endcase
                    end
                end
            end
            else if (q_head.op != OP_NONE && phase_reg == PH_IDLE)
            begin
                fail_next = 1'b0;
                bit_next  = 4'd0;
                case (q_head.op)
                    OP_START:
                    begin
                        scl_next   = 1'b1;
                        sda_next   = 1'b0;
                        phase_next = PH_ST_A;
                        tick_next  = at_least_one(cond_ticks_reg);
                    end
                    OP_STOP:
                    begin
                        scl_next   = 1'b0;
                        sda_next   = 1'b1;
                        phase_next = PH_SP_A;
                        tick_next  = at_least_one(cond_ticks_reg);
                    end
                    OP_WRITE:
                    begin
                        scl_next   = 1'b0;
                        shift_next = q_head.data_byte;
                        sda_next   = !q_head.data_byte[7];
                        phase_next = PH_WR_LOW;
                        tick_next  = at_least_one(half_bit_reg);
                    end
                    OP_READ:
                    begin
                        ack_mode_next = q_head.send_ack;
                        rx_next       = 8'd0;
                        scl_next      = 1'b0;
                        sda_next      = 1'b0;
                        phase_next    = PH_RD_LOW;
                        tick_next     = at_least_one(half_bit_reg);
                    end
                    default:
                    begin
                        sda_next   = 1'b0;
                        phase_next = PH_WA_A;
                        tick_next  = 8'd1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            tick_reg      <= 8'd0;
            bit_reg       <= 4'd0;
            shift_reg     <= 8'd0;
            rx_reg        <= 8'd0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b0;
            ack_mode_reg  <= 1'b0;
            fail_reg      <= 1'b0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            tick_reg      <= tick_next;
            bit_reg       <= bit_next;
            shift_reg     <= shift_next;
            rx_reg        <= rx_next;
            scl_reg       <= scl_next;
            sda_reg       <= sda_next;
            ack_mode_reg  <= ack_mode_next;
            fail_reg      <= fail_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign scl_level    = scl_reg;
    assign sda_pull_low = sda_reg;
    assign busy_res     = (phase_reg != PH_IDLE);
    assign done_res     = done_reg;
    assign read_data    = rx_reg;
    assign ack_failed   = fail_reg;

endmodule

/* hw/rtl/i2c_master_bit_engine_top.sv */
// I2C master bit engine: command intake, item queue and SCL/SDA sequencer.
//
// This block is an I2C master that works on a stream of input beats. Each beat
// is either a command (start, stop, write a byte MSB first, read a byte and
// answer with ACK or NACK, or wait for the slave's ACK) or a tick, where one
// tick stands for one microsecond of bus time and carries the sampled SDA
// level. A command is only taken while the engine is idle; a command that
// arrives while a sequence is running is dropped, and a tick while idle
// changes nothing, but every input beat still yields exactly one output beat
// with the line levels, busy and done flags, the last received byte and the
// ACK failure flag as they stand after that beat. The phase lengths come from
// three configuration registers (ACK timeout, start/stop setup and hold
// ticks, half bit ticks); a zero length acts as one tick. Configuration must
// only be written while no beat is in flight. Internally a front end decodes
// each beat and pushes it into a two-entry queue; the sequencer pops one
// entry per clock into its output register while that register is free or
// being taken, so the block sustains one beat per cycle unless stalled. An
// accepted beat is written into a queue slot and then loaded into the output
// register, which holds its result until the output side takes it. A held
// output beat does not stop intake until the queue is full.
module i2c_master_bit_engine_top
    import i2cbe_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  kind,
    input  logic [7:0]  data_byte,
    input  logic        send_ack,
    input  logic        sda_in,

    output logic        out_valid,
    input  logic        out_stall,
    output logic        scl_level,
    output logic        sda_pull_low,
    output logic        busy_res,
    output logic        done_res,
    output logic [7:0]  read_data,
    output logic        ack_failed
);

`include "assert_macros.svh"

    // Handshake between front end, queue and sequencer.
    logic  q_push;
    logic  q_full;
    logic  q_pop;
    logic  q_valid;
    item_t q_in_item;
    item_t q_head;

    i2cbe_front u_front
    (
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .data_byte (data_byte),
        .send_ack  (send_ack),
        .sda_in    (sda_in),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (q_in_item)
    );

    i2cbe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in_item),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    i2cbe_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .q_valid      (q_valid),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .scl_level    (scl_level),
        .sda_pull_low (sda_pull_low),
        .busy_res     (busy_res),
        .done_res     (done_res),
        .read_data    (read_data),
        .ack_failed   (ack_failed)
    );

    // A finished sequence always leaves the engine idle.
    `ASSERT_IMP(a_done_idle, clk, rst_n, out_valid && done_res, !busy_res, "done while busy")
    // An accepted beat is held either in the queue or in the output register.
    `ASSERT_NXT(a_beat_kept, clk, rst_n, in_valid && !in_stall, q_valid || out_valid, "beat lost")
    // The output register only empties when its beat was taken.
    `ASSERT_IMP(a_out_drop, clk, rst_n, $fell(out_valid), !$past(out_stall), "output dropped")

endmodule

/* verif/i2c_master_bit_engine_checker.sv */
// Checker for the I2C master bit engine: predicts every output beat and compares it.
module i2c_master_bit_engine_checker
    import i2cbe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata,

    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [2:0]  kind,
    input  logic [7:0]  data_byte,
    input  logic        send_ack,
    input  logic        sda_in,

    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        scl_level,
    input  logic        sda_pull_low,
    input  logic        busy_res,
    input  logic        done_res,
    input  logic [7:0]  read_data,
    input  logic        ack_failed,

    output int          pending,
    output int          fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic       scl;
        logic       sda_low;
        logic       busy;
        logic       seq_done;
        logic [7:0] rx_byte;
        logic       fail;
    } line_state_t;

    // Configuration as last written.
    logic [7:0]  ack_limit;
    logic [3:0]  cond_len;
    logic [3:0]  half_len;

    // Predicted engine state.
    phase_t      bus_phase;
    logic [7:0]  ticks_left;
    logic [3:0]  bits_done;
    logic [7:0]  tx_shift;
    logic [7:0]  rx_shift;
    logic        scl_q;
    logic        sda_low_q;
    logic        ack_mode_q;
    logic        fail_q;

    line_state_t line_q[$];

    function automatic logic [7:0] stretch(input logic [3:0] v);
        return (v == 4'd0) ? 8'd1 : {4'd0, v};
    endfunction

    function automatic void go_to(input phase_t ph, input logic [7:0] n);
        bus_phase  = ph;
        ticks_left = n;
    endfunction

    function automatic void open_stop();
        scl_q     = 1'b0;
        sda_low_q = 1'b1;
        go_to(PH_SP_A, stretch(cond_len));
    endfunction

    function automatic void drive_tx_bit();
        sda_low_q = ~tx_shift[7];
        go_to(PH_WR_LOW, stretch(half_len));
    endfunction

    function automatic void reset_engine();
        ack_limit  = ACK_TIMEOUT_RST;
        cond_len   = COND_TICKS_RST;
        half_len   = HALF_BIT_RST;
        bus_phase  = PH_IDLE;
        ticks_left = 8'd0;
        bits_done  = 4'd0;
        tx_shift   = 8'd0;
        rx_shift   = 8'd0;
        scl_q      = 1'b1;
        sda_low_q  = 1'b0;
        ack_mode_q = 1'b0;
        fail_q     = 1'b0;
    endfunction

    // One microsecond of bus time; returns 1 when the running sequence ends on it.
    function automatic logic tick_bus(input logic line);
        logic fin;
        fin = 1'b0;
        if (bus_phase == PH_WA_POLL)
        begin
            if (!line)
            begin
                scl_q     = 1'b0;
                bus_phase = PH_IDLE;
                fin       = 1'b1;
            end
            else if (ticks_left >= ack_limit)
            begin
                fail_q = 1'b1;
                open_stop();
            end
            else
            begin
                ticks_left = ticks_left + 8'd1;
            end
        end
        else if (ticks_left > 8'd1)
        begin
            ticks_left = ticks_left - 8'd1;
        end
        else
        begin
            case (bus_phase)
                PH_ST_A:
                begin
                    sda_low_q = 1'b1;
                    go_to(PH_ST_B, stretch(cond_len));
                end
                PH_ST_B:
                begin
                    scl_q     = 1'b0;
                    bus_phase = PH_IDLE;
                    fin       = 1'b1;
                end
                PH_SP_A:
                begin
                    scl_q     = 1'b1;
                    sda_low_q = 1'b0;
                    go_to(PH_SP_B, stretch(cond_len));
                end
                PH_SP_B:
                begin
                    bus_phase = PH_IDLE;
                    fin       = 1'b1;
                end
                PH_WR_LOW:
                begin
                    scl_q = 1'b1;
                    go_to(PH_WR_HIGH, stretch(half_len));
                end
                PH_WR_HIGH:
                begin
                    scl_q = 1'b0;
                    go_to(PH_WR_TAIL, stretch(half_len));
                end
                PH_WR_TAIL:
                begin
                    bits_done = bits_done + 4'd1;
                    if (bits_done >= BITS_PER_BYTE)
                    begin
                        bus_phase = PH_IDLE;
                        fin       = 1'b1;
                    end
                    else
                    begin
                        tx_shift = {tx_shift[6:0], 1'b0};
                        drive_tx_bit();
                    end
                end
                PH_RD_LOW:
                begin
                    scl_q    = 1'b1;
                    rx_shift = {rx_shift[6:0], line};
                    go_to(PH_RD_HIGH, 8'd1);
                end
                PH_RD_HIGH:
                begin
                    bits_done = bits_done + 4'd1;
                    scl_q     = 1'b0;
                    if (bits_done >= BITS_PER_BYTE)
                    begin
                        sda_low_q = ack_mode_q;
                        go_to(PH_AK_LOW, stretch(half_len));
                    end
                    else
                    begin
                        go_to(PH_RD_LOW, stretch(half_len));
                    end
                end
                PH_AK_LOW:
                begin
                    scl_q = 1'b1;
                    go_to(PH_AK_HIGH, stretch(half_len));
                end
                PH_AK_HIGH:
                begin
                    scl_q     = 1'b0;
                    bus_phase = PH_IDLE;
                    fin       = 1'b1;
                end
                PH_WA_A:
                begin
                    scl_q = 1'b1;
                    go_to(PH_WA_B, 8'd1);
                end
                PH_WA_B:
                begin
                    bus_phase  = PH_WA_POLL;
                    ticks_left = 8'd0;
                end
                default:
                begin
                    bus_phase = PH_IDLE;
                end
            endcase
        end
        return fin;
    endfunction

    function automatic void take_command(input logic [2:0] k, input logic [7:0] d,
                                         input logic a);
        fail_q    = 1'b0;
        bits_done = 4'd0;
        case (k)
            KIND_START:
            begin
                scl_q     = 1'b1;
                sda_low_q = 1'b0;
                go_to(PH_ST_A, stretch(cond_len));
            end
            KIND_STOP:
            begin
                open_stop();
            end
            KIND_WRITE:
            begin
                scl_q    = 1'b0;
                tx_shift = d;
                drive_tx_bit();
            end
            KIND_READ:
            begin
                ack_mode_q = a;
                rx_shift   = 8'd0;
                scl_q      = 1'b0;
                sda_low_q  = 1'b0;
                go_to(PH_RD_LOW, stretch(half_len));
            end
            default:
            begin
                sda_low_q = 1'b0;
                go_to(PH_WA_A, 8'd1);
            end
        endcase
    endfunction

    // Line levels and flags after one input beat.
    function automatic line_state_t predict_lines(input logic [2:0] k, input logic [7:0] d,
                                                  input logic a, input logic s);
        line_state_t r;
        logic        fin;
        fin = 1'b0;
        if (k == KIND_TICK)
        begin
            if (bus_phase != PH_IDLE)
            begin
                fin = tick_bus(s);
            end
        end
        else if (k <= KIND_WAIT && bus_phase == PH_IDLE)
        begin
            take_command(k, d, a);
        end
        r.scl      = scl_q;
        r.sda_low  = sda_low_q;
        r.busy     = (bus_phase != PH_IDLE);
        r.seq_done = fin;
        r.rx_byte  = rx_shift;
        r.fail     = fail_q;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s expected %0h got %0h", name, want, got));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        line_state_t want;
        if (!rst_n)
        begin
            reset_engine();
            line_q.delete();
            fail_count = 0;
            pending <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (line_q.size() == 0)
                begin
                    report_mismatch("output beat with nothing expected");
                end
                else
                begin
                    want = line_q.pop_front();
                    check_field("scl_level", 8'(want.scl), 8'(scl_level));
                    check_field("sda_pull_low", 8'(want.sda_low), 8'(sda_pull_low));
                    check_field("busy_res", 8'(want.busy), 8'(busy_res));
                    check_field("done_res", 8'(want.seq_done), 8'(done_res));
                    check_field("read_data", want.rx_byte, read_data);
                    check_field("ack_failed", 8'(want.fail), 8'(ack_failed));
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ACK_TIMEOUT: ack_limit = cfg_wdata;
                    CFG_COND_TICKS:  cond_len  = cfg_wdata[3:0];
                    CFG_HALF_BIT:    half_len  = cfg_wdata[3:0];
                    default:         ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                line_q.push_back(predict_lines(kind, data_byte, send_ack, sda_in));
            end
            pending <= line_q.size();
        end
    end

endmodule

/* verif/i2c_master_bit_engine_top_tb.sv */
// Top of the I2C master bit engine testbench: clock, reset, stimulus and verdict.
module i2c_master_bit_engine_top_tb
    import i2cbe_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // Kind codes that the engine does not use; beats carrying them are ignored.
    localparam logic [2:0] KIND_SPARE_A = 3'd6;
    localparam logic [2:0] KIND_SPARE_B = 3'd7;

    localparam int BEAT_TARGET = 1750;
    localparam int RAND_PHASES = 8;
    // Cycles with no beat accepted on either side before the run is declared hung.
    localparam int QUIET_LIMIT = 2000;
    // Cycles to watch the output after the last expected beat has arrived.
    localparam int SETTLE_CYCLES = 16;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_wdata;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  kind;
    logic [7:0]  data_byte;
    logic        send_ack;
    logic        sda_in;
    logic        out_valid;
    logic        out_stall;
    logic        scl_level;
    logic        sda_pull_low;
    logic        busy_res;
    logic        done_res;
    logic [7:0]  read_data;
    logic        ack_failed;

    int          pending;
    int          fail_count;

    // Stimulus bookkeeping. The cur_* values are the effective phase lengths
    // (a zero register acts as one tick) and the ACK timeout, mirrored here so
    // that the sender knows how many ticks each command needs.
    int          beat_count = 0;
    int          cur_ack    = 250;
    int          cur_cond   = 4;
    int          cur_half   = 2;
    int          clk_count  = 0;
    int          quiet_cycles = 0;
    int          stall_left = 0;
    logic        calm = 1'b0;

    i2c_master_bit_engine_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .data_byte    (data_byte),
        .send_ack     (send_ack),
        .sda_in       (sda_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .scl_level    (scl_level),
        .sda_pull_low (sda_pull_low),
        .busy_res     (busy_res),
        .done_res     (done_res),
        .read_data    (read_data),
        .ack_failed   (ack_failed)
    );

    i2c_master_bit_engine_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .data_byte    (data_byte),
        .send_ack     (send_ack),
        .sda_in       (sda_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .scl_level    (scl_level),
        .sda_pull_low (sda_pull_low),
        .busy_res     (busy_res),
        .done_res     (done_res),
        .read_data    (read_data),
        .ack_failed   (ack_failed),
        .pending      (pending),
        .fail_count   (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        clk_count <= clk_count + 1;
    end

    // Idling is allowed in three windows out of four, so that there are long
    // stretches where both sides run flat out; in the last phase it stops.
    function automatic bit idling_allowed();
        return !calm && ((clk_count / 256) % 4 != 3);
    endfunction

    // Output back-pressure: random stall bursts.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (calm)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (idling_allowed() && $urandom_range(0, 7) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 5);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Hang detection: any accepted beat on either channel restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic int stretch(input logic [3:0] v);
        return (v == 4'd0) ? 1 : int'(v);
    endfunction

    // Sends one beat and returns at the clock edge where it is accepted. A
    // random gap may come first. Valid is only lowered when a gap is taken,
    // so back-to-back beats keep it high without a glitch.
    task automatic send_beat(input logic [2:0] k, input logic [7:0] d, input logic a,
                             input logic s);
        int gap;
        gap = 0;
        if (idling_allowed() && $urandom_range(0, 9) == 0)
        begin
            gap = $urandom_range(1, 6);
        end
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        kind      <= k;
        data_byte <= d;
        send_ack  <= a;
        sda_in    <= s;
        do
            @(posedge clk);
        while (in_stall);
        beat_count++;
    endtask

    task automatic tick_at(input logic lvl);
        send_beat(KIND_TICK, 8'($urandom), 1'($urandom), lvl);
    endtask

    task automatic command(input logic [2:0] k, input logic [7:0] d, input logic a);
        send_beat(k, d, a, 1'($urandom));
    endtask

    // Runs the ticks that the current command needs, with random SDA levels.
    // Now and then a command or an unused code is slipped in while the engine
    // is still busy; it must be ignored. A few spare ticks at the end land on
    // an idle engine.
    task automatic run_ticks(input int need);
        for (int i = 0; i < need; i++)
        begin
            if (i > 0 && $urandom_range(0, 24) == 0)
            begin
                command(3'($urandom_range(1, 5)), 8'($urandom), 1'($urandom));
            end
            if ($urandom_range(0, 39) == 0)
            begin
                command($urandom_range(0, 1) ? KIND_SPARE_A : KIND_SPARE_B,
                        8'($urandom), 1'($urandom));
            end
            tick_at(1'($urandom));
        end
        repeat ($urandom_range(0, 2)) tick_at(1'($urandom));
    endtask

    // ACK wait. On success the slave holds SDA high for at most the tolerated
    // number of samples and then pulls it low; on give-up SDA stays high one
    // sample past the timeout, after which the engine runs a stop by itself.
    task automatic ack_phase(input bit give_up);
        int highs;
        command(KIND_WAIT, 8'($urandom), 1'($urandom));
        tick_at(1'($urandom));
        tick_at(1'($urandom));
        if (give_up)
        begin
            repeat (cur_ack + 1) tick_at(1'b1);
            run_ticks(2 * cur_cond);
        end
        else
        begin
            highs = $urandom_range(0, (cur_ack < 6) ? cur_ack : 6);
            if ($urandom_range(0, 7) == 0)
            begin
                highs = cur_ack;
            end
            repeat (highs) tick_at(1'b1);
            tick_at(1'b0);
        end
    endtask

    // One bus transfer: start, a few bytes written or read, stop. Sometimes
    // the start or the stop is left out to give broken sequences.
    task automatic transfer();
        int parts;
        bit failed;
        failed = 1'b0;
        if ($urandom_range(0, 7) != 0)
        begin
            command(KIND_START, 8'($urandom), 1'($urandom));
            run_ticks(2 * cur_cond);
        end
        parts = $urandom_range(1, 3);
        for (int p = 0; p < parts && !failed; p++)
        begin
            if ($urandom_range(0, 1) == 1)
            begin
                command(KIND_WRITE, 8'($urandom), 1'($urandom));
                run_ticks(24 * cur_half);
                failed = ($urandom_range(0, 7) == 0);
                ack_phase(failed);
            end
            else
            begin
                command(KIND_READ, 8'($urandom), 1'($urandom));
                run_ticks(10 * cur_half + 8);
            end
        end
        if (!failed && $urandom_range(0, 7) != 0)
        begin
            command(KIND_STOP, 8'($urandom), 1'($urandom));
            run_ticks(2 * cur_cond);
        end
    endtask

    // Lowers valid and holds off until every expected beat has come back.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Writes all three registers; only called with the engine drained.
    task automatic apply_config(input logic [7:0] ack_to, input logic [7:0] cond,
                                input logic [7:0] half);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ACK_TIMEOUT;
        cfg_wdata <= ack_to;
        @(posedge clk);
        cfg_index <= CFG_COND_TICKS;
        cfg_wdata <= cond;
        @(posedge clk);
        cfg_index <= CFG_HALF_BIT;
        cfg_wdata <= half;
        @(posedge clk);
        cfg_we   <= 1'b0;
        cur_ack  = int'(ack_to);
        cur_cond = stretch(cond[3:0]);
        cur_half = stretch(half[3:0]);
    endtask

    initial
    begin
        int budget;
        int phase_start;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_ACK_TIMEOUT;
        cfg_wdata <= 8'd0;
        in_valid  <= 1'b0;
        kind      <= KIND_TICK;
        data_byte <= 8'd0;
        send_ack  <= 1'b0;
        sda_in    <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. A start under the reset configuration first.
        command(KIND_START, 8'd0, 1'b0);
        run_ticks(2 * cur_cond);
        drain();

        // All registers zero: every phase lasts one tick and the very first
        // high ACK sample fails.
        apply_config(8'd0, 8'd0, 8'd0);
        tick_at(1'b0);
        tick_at(1'b1);
        command(KIND_SPARE_A, 8'hFF, 1'b1);
        command(KIND_SPARE_B, 8'h00, 1'b0);
        command(KIND_START, 8'hFF, 1'b1);
        run_ticks(2);
        command(KIND_WRITE, 8'hFF, 1'b1);
        run_ticks(24);
        ack_phase(1'b1);
        command(KIND_WRITE, 8'h00, 1'b0);
        command(KIND_READ, 8'hFF, 1'b1);
        run_ticks(24);
        ack_phase(1'b0);
        command(KIND_READ, 8'hA5, 1'b1);
        repeat (18) tick_at(1'b1);
        command(KIND_READ, 8'h5A, 1'b0);
        repeat (18) tick_at(1'b0);
        command(KIND_STOP, 8'h00, 1'b0);
        run_ticks(2);
        command(KIND_STOP, 8'hFF, 1'b1);
        run_ticks(2);

        // Random part, one configuration per phase: the largest lengths and
        // timeout first, then the smallest non-zero ones, then random values
        // with random upper bits on the four-bit registers. The last phase has
        // no idling on either side.
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            drain();
            case (ph)
                0: apply_config(8'd255, 8'hFF, 8'hFF);
                1: apply_config(8'd1, 8'd1, 8'd1);
                default: apply_config(8'($urandom_range(0, 16)),
                                      {4'($urandom), 4'($urandom_range(0, 5))},
                                      {4'($urandom), 4'($urandom_range(0, 3))});
            endcase
            if (ph == RAND_PHASES - 1)
            begin
                calm <= 1'b1;
            end
            budget = (BEAT_TARGET - beat_count) / (RAND_PHASES - ph);
            phase_start = beat_count;
            while (beat_count - phase_start < budget)
            begin
                transfer();
                if ($urandom_range(0, 3) == 0)
                begin
                    repeat ($urandom_range(1, 3))
                    begin
                        send_beat(3'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
                    end
                end
                // Once in a while the sender holds off until the output side
                // has caught up completely.
                if ($urandom_range(0, 9) == 0 || (ph == 3 && beat_count - phase_start
                                                  >= budget / 2 && budget > 0))
                begin
                    drain();
                end
            end
        end

        // Wait for the last expected beat, then watch a little longer for any
        // stray output beat before giving the verdict.
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
